// ===== hdl/bmq_pkg.sv =====
// Shared constants, codes and control types of the budgeted message queue.
`timescale 1ns / 1ps
package bmq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SIZE_BITS   = 16;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_W = (SIZE_BITS < 16) ? SIZE_BITS : 16;
    localparam int TOTAL_W = (SIZE_BITS + PTR_W + 1 > 22) ? SIZE_BITS + PTR_W + 1 : 22;
    localparam int CMP_W   = ((CNT_W > 6) ? CNT_W : 6) + 1;

    localparam int TDATA_W = 80;
    localparam logic [20:0] TOTAL_MAX = 21'h1F_FFFF;

    localparam logic [5:0]  RST_MAX_COUNT = 6'd32;
    localparam logic [20:0] RST_MAX_SIZE  = 21'd65536;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_PRIO = 2'd1;
    localparam logic [1:0] OP_GET  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_REFUSED   = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_DELIVERED = 2'd3;

    localparam logic [1:0] CFG_MAX_COUNT = 2'd0;
    localparam logic [1:0] CFG_MAX_SIZE  = 2'd1;

    typedef struct packed {
        logic latch;
        logic add_exec;
        logic emit_empty;
        logic rd_head;
        logic load;
        logic first;
        logic look;
        logic emit_cur;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       single;
        logic       take;
        logic       out_free;
    } stat_t;

endpackage

// ===== hdl/budgeted_message_queue.sv =====
// Top level of the budgeted message queue: controller and datapath.
// An add is decoded after acceptance and, once the output register is free, writes its result word there.
// A get is decoded, then each delivered word passes S_LOAD, S_LOOK and S_EMIT (S_LOOK is skipped for
// the final word when it empties the queue), paced by the single read port of the store.
// One input word is in work at a time; the next is accepted once results are queued.
// Reset (rst_n, asynchronous, active low) empties the queue and restores the limits.
`timescale 1ns / 1ps
module budgeted_message_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [20:0]                  cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // msg_tag[31:0], msg_size[47:32], batch_max_count[53:48], batch_max_size[74:54]
    input  logic [bmq_pkg::TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_tag[31:0], out_size[47:32], queued_count[53:48], queued_size[74:54]
    output logic [bmq_pkg::TDATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import bmq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bmq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bmq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hdl/bmq_ctrl.sv =====
// Controller state machine of the budgeted message queue.
`timescale 1ns / 1ps
module bmq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  bmq_pkg::stat_t stat,
    output bmq_pkg::cmd_t  cmd
);
    import bmq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_LOOK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        first_next = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.op == OP_ADD || stat.op == OP_PRIO)
                begin
                    if (stat.out_free)
                    begin
                        cmd.add_exec = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (stat.op == OP_GET)
                begin
                    priority if (stat.empty)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_empty = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        first_next  = 1'b1;
                        state_next  = S_LOAD;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                cmd.first  = first_reg;
                first_next = 1'b0;
                state_next = stat.single ? S_EMIT : S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_cur = 1'b1;
                    state_next   = stat.take ? S_LOAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

endmodule

// ===== hdl/bmq_dp.sv =====
// Datapath of the budgeted message queue: descriptor store, counters, output register.
`timescale 1ns / 1ps
module bmq_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [20:0]                  cfg_data,
    input  logic [bmq_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                   s_axis_tuser,
    input  bmq_pkg::cmd_t                cmd,
    output bmq_pkg::stat_t               stat,
    input  logic                         m_axis_tready,
    output logic                         m_axis_tvalid,
    output logic [bmq_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import bmq_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W+1:0] SUM_WRAP = (PTR_W + 2)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [31:0]        tag_mem [QUEUE_DEPTH];
    logic [STORE_W-1:0] size_mem [QUEUE_DEPTH];

    logic [1:0]         op_reg;
    logic [31:0]        tag_in_reg;
    logic [STORE_W-1:0] size_in_reg;
    logic [5:0]         bcount_reg;
    logic [20:0]        bsize_reg;
    logic [5:0]         max_count_reg;
    logic [20:0]        max_size_reg;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   n_reg;
    logic [TOTAL_W-1:0] taken_reg;
    logic [31:0]        cur_tag_reg;
    logic [STORE_W-1:0] cur_size_reg;
    logic               take_reg;
    logic [31:0]        rd_tag_reg;
    logic [STORE_W-1:0] rd_size_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [31:0]        out_tag_reg;
    logic [15:0]        out_size_reg;
    logic               out_last_reg;
    logic [5:0]         out_count_reg;
    logic [20:0]        out_total_reg;

    logic [PTR_W-1:0]   head_inc, head_dec, tail_slot, wr_slot, rd_addr;
    logic [PTR_W+1:0]   tail_sum;
    logic               add_ok, wr_en, rd_en, out_free, emit;
    logic [TOTAL_W-1:0] add_total, look_total;
    logic [CMP_W-1:0]   look_count;
    logic [1:0]         emit_status;

    always_comb
    begin
        head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
        tail_sum = (PTR_W + 2)'(head_reg) + (PTR_W + 2)'(count_reg);
        if (tail_sum >= SUM_WRAP)
        begin
            tail_sum = tail_sum - SUM_WRAP;
        end
        tail_slot = tail_sum[PTR_W-1:0];
        wr_slot   = (op_reg == OP_PRIO) ? head_dec : tail_slot;

        add_total = total_reg + TOTAL_W'(size_in_reg);
        add_ok    = (count_reg < CNT_FULL)
                    && (op_reg == OP_PRIO || count_reg == '0
                        || (CMP_W'(count_reg) < CMP_W'(max_count_reg)
                            && add_total <= TOTAL_W'(max_size_reg)));
        wr_en     = cmd.add_exec && add_ok;

        rd_en   = cmd.rd_head || cmd.load;
        rd_addr = cmd.load ? head_inc : head_reg;

        look_count = CMP_W'(n_reg) + 1'b1;
        look_total = taken_reg + TOTAL_W'(rd_size_reg);

        head_next  = head_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (wr_en)
        begin
            if (op_reg == OP_PRIO)
            begin
                head_next = head_dec;
            end
            count_next = count_reg + 1'b1;
            total_next = add_total;
        end
        else if (cmd.load)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            total_next = total_reg - TOTAL_W'(rd_size_reg);
        end

        out_free = !out_valid_reg || m_axis_tready;
        emit     = cmd.add_exec || cmd.emit_empty || cmd.emit_cur;
        priority if (cmd.emit_cur)
        begin
            emit_status = ST_DELIVERED;
        end
        else if (cmd.emit_empty)
        begin
            emit_status = ST_EMPTY;
        end
        else if (add_ok)
        begin
            emit_status = ST_ADDED;
        end
        else
        begin
            emit_status = ST_REFUSED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_slot]  <= tag_in_reg;
            size_mem[wr_slot] <= size_in_reg;
        end
        if (rd_en)
        begin
            rd_tag_reg  <= tag_mem[rd_addr];
            rd_size_reg <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= s_axis_tuser;
            tag_in_reg  <= s_axis_tdata[31:0];
            size_in_reg <= STORE_W'(s_axis_tdata[47:32]);
            bcount_reg  <= s_axis_tdata[53:48];
            bsize_reg   <= s_axis_tdata[74:54];
        end
        if (cmd.load)
        begin
            cur_tag_reg  <= rd_tag_reg;
            cur_size_reg <= rd_size_reg;
            n_reg        <= cmd.first ? CNT_W'(1) : n_reg + 1'b1;
            taken_reg    <= (cmd.first ? '0 : taken_reg) + TOTAL_W'(rd_size_reg);
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_tag_reg    <= cmd.emit_cur ? cur_tag_reg : '0;
            out_size_reg   <= cmd.emit_cur ? 16'(cur_size_reg) : '0;
            out_last_reg   <= cmd.emit_cur ? !take_reg : 1'b1;
            out_count_reg  <= 6'(count_next);
            out_total_reg  <= (total_next > TOTAL_W'(TOTAL_MAX)) ? TOTAL_MAX
                              : 21'(total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= RST_MAX_COUNT;
            max_size_reg  <= RST_MAX_SIZE;
            head_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MAX_COUNT)
            begin
                max_count_reg <= cfg_data[5:0];
            end
            if (cfg_we && cfg_index == CFG_MAX_SIZE)
            begin
                max_size_reg <= cfg_data;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if (cmd.load)
            begin
                take_reg <= 1'b0;
            end
            else if (cmd.look)
            begin
                take_reg <= (look_count <= CMP_W'(bcount_reg))
                            && (look_total <= TOTAL_W'(bsize_reg));
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.single   = (count_reg == CNT_W'(1));
    assign stat.take     = take_reg;
    assign stat.out_free = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_total_reg, out_count_reg, out_size_reg, out_tag_reg};

endmodule

// ===== bench/budgeted_message_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the budgeted message queue, checked against a predictor.
module budgeted_message_queue_test;
    import bmq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] tag;
        logic [15:0] size;
        logic        last;
        logic [5:0]  count;
        logic [20:0] total;
    } result_word_t;

    class message_book;
        logic [31:0]  tag_ring [QUEUE_DEPTH];
        logic [15:0]  size_ring [QUEUE_DEPTH];
        int           head;
        int           held;
        longint       held_size;
        int           cap_count;
        longint       cap_size;
        result_word_t due_words [$];
        int           mismatches;

        function new();
            head       = 0;
            held       = 0;
            held_size  = 0;
            cap_count  = 32;
            cap_size   = 65536;
            mismatches = 0;
        endfunction

        function void set_limits(logic [5:0] count, logic [20:0] size);
            cap_count = count;
            cap_size  = size;
        endfunction

        function void push_word(logic [1:0] status, logic [31:0] tag, logic [15:0] size,
                                logic last);
            result_word_t w;
            w.status = status;
            w.tag    = tag;
            w.size   = size;
            w.last   = last;
            w.count  = held[5:0];
            w.total  = (held_size > TOTAL_MAX) ? TOTAL_MAX : held_size[20:0];
            due_words.push_back(w);
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] tag, logic [15:0] size,
                                   logic [5:0] bcount, logic [20:0] bsize);
            bit          admit;
            bit          more;
            int          slot;
            int          n;
            int          i;
            longint      taken;
            logic [15:0] s;
            case (op)
                OP_ADD, OP_PRIO:
                begin
                    if (held >= QUEUE_DEPTH)
                        admit = 1'b0;
                    else if (op == OP_PRIO || held == 0)
                        admit = 1'b1;
                    else
                        admit = held < cap_count && held_size + size <= cap_size;
                    if (!admit)
                        push_word(ST_REFUSED, 32'h0, 16'h0, 1'b1);
                    else
                    begin
                        if (op == OP_ADD)
                            slot = (head + held) % QUEUE_DEPTH;
                        else
                        begin
                            head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                            slot = head;
                        end
                        tag_ring[slot]  = tag;
                        size_ring[slot] = size;
                        held++;
                        held_size += size;
                        push_word(ST_ADDED, 32'h0, 16'h0, 1'b1);
                    end
                end
                OP_GET:
                begin
                    if (held == 0)
                        push_word(ST_EMPTY, 32'h0, 16'h0, 1'b1);
                    else
                    begin
                        n     = 0;
                        taken = 0;
                        more  = 1'b1;
                        while (more && n < held)
                        begin
                            s = size_ring[(head + n) % QUEUE_DEPTH];
                            if (n == 0 || (n + 1 <= bcount && taken + s <= bsize))
                            begin
                                n++;
                                taken += s;
                            end
                            else
                                more = 1'b0;
                        end
                        for (i = 0; i < n; i++)
                        begin
                            slot = head;
                            head = (head + 1) % QUEUE_DEPTH;
                            held--;
                            held_size -= size_ring[slot];
                            push_word(ST_DELIVERED, tag_ring[slot], size_ring[slot], i + 1 == n);
                        end
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected word", $time);
                    $display("  actual   status=%0d tag=%h size=%0d last=%0b count=%0d total=%0d",
                             got.status, got.tag, got.size, got.last, got.count, got.total);
                end
            end
            else
            begin
                want = due_words[0];
                due_words.delete(0);
                if (got.status !== want.status || got.tag !== want.tag || got.size !== want.size
                    || got.last !== want.last || got.count !== want.count
                    || got.total !== want.total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: word mismatch", $time);
                        $display("  expected status=%0d tag=%h size=%0d last=%0b count=%0d total=%0d",
                                 want.status, want.tag, want.size, want.last, want.count,
                                 want.total);
                        $display("  actual   status=%0d tag=%h size=%0d last=%0b count=%0d total=%0d",
                                 got.status, got.tag, got.size, got.last, got.count, got.total);
                    end
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [20:0]         cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    message_book book;
    int          tx_calm = 0;
    int          rx_calm = 0;

    budgeted_message_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(5, 20);
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic send_word(logic [1:0] op, logic [31:0] tag, logic [15:0] size,
                             logic [5:0] bcount, logic [20:0] bsize);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, bsize, bcount, size, tag};
        do @(posedge clk); while (!s_axis_tready);
        book.note_request(op, tag, size, bcount, bsize);
        @(negedge clk);
    endtask

    // hold off until every expected word is out and any ignored word has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (book.due_words.size() > 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_limits(logic [5:0] count, logic [20:0] size);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_COUNT;
        cfg_data  <= {15'b0, count};
        @(negedge clk);
        cfg_index <= CFG_MAX_SIZE;
        cfg_data  <= size;
        @(negedge clk);
        cfg_we <= 1'b0;
        book.set_limits(count, size);
    endtask

    task automatic run_phase(int words, int add_pct, int bc_hi);
        int          done;
        int          pick;
        logic [1:0]  op;
        logic [5:0]  bc;
        logic [20:0] bs;
        done = 0;
        while (done < words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                op = ($urandom_range(0, 2) == 0) ? OP_PRIO : OP_ADD;
            else if (pick < 97)
                op = OP_GET;
            else
                op = OP_NONE;
            if ($urandom_range(0, 3) == 0)
                bc = 6'($urandom_range(0, 63));
            else
                bc = 6'($urandom_range(0, bc_hi));
            case ($urandom_range(0, 3))
                0:       bs = 21'($urandom_range(0, 2097151));
                1:       bs = 21'd0;
                default: bs = 21'($urandom_range(0, 20000));
            endcase
            send_word(op, $urandom, pick_size(), bc, bs);
            if (op != OP_NONE)
                done++;
        end
    endtask

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            book.check_word({m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32],
                             m_axis_tlast, m_axis_tdata[53:48], m_axis_tdata[74:54]});
            @(negedge clk);
        end
    end

    initial
    begin
        book          = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MAX_COUNT;
        cfg_data      = 21'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd0,  21'd0);
        send_word(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F, 21'h1F_FFFF);
        send_word(OP_ADD,  32'hFFFF_FFFF, 16'h0000, 6'h3F, 21'h1F_FFFF);
        send_word(OP_ADD,  32'h0000_0000, 16'hFFFF, 6'd0,  21'd0);
        send_word(OP_PRIO, 32'hA5A5_5A5A, 16'h0001, 6'd0,  21'd0);
        send_word(OP_ADD,  32'h1234_5678, 16'hFFFF, 6'd0,  21'd0);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd0,  21'd0);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd32, 21'h1F_FFFF);
        send_word(OP_PRIO, 32'hFFFF_0000, 16'hFFFF, 6'd0,  21'd0);
        send_word(OP_PRIO, 32'h0000_FFFF, 16'hFFFF, 6'd0,  21'd0);
        send_word(OP_ADD,  32'h0F0F_0F0F, 16'h0001, 6'd0,  21'd0);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd1,  21'h1F_FFFF);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'h3F, 21'd0);
        send_word(OP_ADD,  32'h0000_0001, 16'd7,    6'd0,  21'd0);
        send_word(OP_ADD,  32'h0000_0002, 16'd9,    6'd0,  21'd0);
        send_word(OP_ADD,  32'h0000_0003, 16'd11,   6'd0,  21'd0);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd2,  21'd16);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd32, 21'd0);

        write_limits(6'd0, 21'd0);
        send_word(OP_ADD,  32'hF0F0_F0F0, 16'd5,    6'd0,  21'd0);
        send_word(OP_ADD,  32'h3C3C_3C3C, 16'd0,    6'd0,  21'd0);
        send_word(OP_PRIO, 32'hC3C3_C3C3, 16'd0,    6'd0,  21'd0);
        send_word(OP_GET,  32'h0000_0000, 16'h0000, 6'd2,  21'd10);

        write_limits(6'd32, 21'h1F_FFFF);
        run_phase(40, 95, 1);
        write_limits(6'd1, 21'd0);
        run_phase(20, 50, 4);
        write_limits(6'd63, 21'd1000);
        run_phase(20, 55, 6);
        write_limits(6'd8, 21'd65536);
        run_phase(20, 50, 8);
        write_limits(6'd0, 21'h1F_FFFF);
        run_phase(15, 50, 4);
        write_limits(6'd32, 21'd65536);
        run_phase(20, 45, 32);

        settle();
        if (book.mismatches == 0 && book.due_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== budgeted_message_queue.f =====
hdl/bmq_pkg.sv
hdl/bmq_ctrl.sv
hdl/bmq_dp.sv
hdl/budgeted_message_queue.sv
bench/budgeted_message_queue_test.sv
